// ===== design/pcr_pkg.sv =====
// Shared types, codes and operand tables for the pose composition unit.
`default_nettype none

package pcr_pkg;

    localparam int POS_WIDTH_DEF  = 32;
    localparam int QUAT_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        FN_LOAD      = 2'd0,
        FN_COMPOSE   = 2'd1,
        FN_RELATIVE  = 2'd2,
        FN_TRANSFORM = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        QC_W = 2'd0,
        QC_X = 2'd1,
        QC_Y = 2'd2,
        QC_Z = 2'd3
    } comp_t;

    // rounded pair products feeding the rotation matrix
    typedef enum logic [3:0] {
        PR_XX = 4'd0,
        PR_YY = 4'd1,
        PR_ZZ = 4'd2,
        PR_XY = 4'd3,
        PR_XZ = 4'd4,
        PR_YZ = 4'd5,
        PR_WX = 4'd6,
        PR_WY = 4'd7,
        PR_WZ = 4'd8
    } pair_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PAIR_MUL,
        S_PAIR_ACC,
        S_MAT,
        S_ROT_MUL,
        S_ROT_ACC,
        S_HAM_MUL,
        S_HAM_ACC,
        S_TOP,
        S_SHIFT,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        comp_t a;
        comp_t b;
    } op_pair_t;

    typedef struct packed {
        comp_t a;
        comp_t b;
        logic  neg;
    } ham_term_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } rd_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rd_stat_t;

    function automatic op_pair_t pair_ops(input logic [3:0] k);
        op_pair_t r;
        case (k)
            PR_XX:   r = '{QC_X, QC_X};
            PR_YY:   r = '{QC_Y, QC_Y};
            PR_ZZ:   r = '{QC_Z, QC_Z};
            PR_XY:   r = '{QC_X, QC_Y};
            PR_XZ:   r = '{QC_X, QC_Z};
            PR_YZ:   r = '{QC_Y, QC_Z};
            PR_WX:   r = '{QC_W, QC_X};
            PR_WY:   r = '{QC_W, QC_Y};
            PR_WZ:   r = '{QC_W, QC_Z};
            default: r = '{QC_W, QC_W};
        endcase
        return r;
    endfunction

    // Hamilton product terms, four per output component in w, x, y, z order
    function automatic ham_term_t ham_ops(input logic [3:0] t);
        ham_term_t r;
        case (t)
            4'd0:    r = '{QC_W, QC_W, 1'b0};
            4'd1:    r = '{QC_X, QC_X, 1'b1};
            4'd2:    r = '{QC_Y, QC_Y, 1'b1};
            4'd3:    r = '{QC_Z, QC_Z, 1'b1};
            4'd4:    r = '{QC_W, QC_X, 1'b0};
            4'd5:    r = '{QC_X, QC_W, 1'b0};
            4'd6:    r = '{QC_Y, QC_Z, 1'b0};
            4'd7:    r = '{QC_Z, QC_Y, 1'b1};
            4'd8:    r = '{QC_W, QC_Y, 1'b0};
            4'd9:    r = '{QC_X, QC_Z, 1'b1};
            4'd10:   r = '{QC_Y, QC_W, 1'b0};
            4'd11:   r = '{QC_Z, QC_X, 1'b0};
            4'd12:   r = '{QC_W, QC_Z, 1'b0};
            4'd13:   r = '{QC_X, QC_Y, 1'b0};
            4'd14:   r = '{QC_Y, QC_X, 1'b1};
            4'd15:   r = '{QC_Z, QC_W, 1'b0};
            default: r = '{QC_W, QC_W, 1'b0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/pcr_req_if.sv =====
// Request channel: function code and input pose or point.
`default_nettype none

interface pcr_req_if
    import pcr_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [POS_WIDTH-1:0]  in_pos_x;
    logic signed [POS_WIDTH-1:0]  in_pos_y;
    logic signed [POS_WIDTH-1:0]  in_pos_z;
    logic signed [QUAT_WIDTH-1:0] in_quat_w;
    logic signed [QUAT_WIDTH-1:0] in_quat_x;
    logic signed [QUAT_WIDTH-1:0] in_quat_y;
    logic signed [QUAT_WIDTH-1:0] in_quat_z;

    modport source (
        output valid, func, in_pos_x, in_pos_y, in_pos_z,
               in_quat_w, in_quat_x, in_quat_y, in_quat_z,
        input  ready
    );
    modport sink (
        input  valid, func, in_pos_x, in_pos_y, in_pos_z,
               in_quat_w, in_quat_x, in_quat_y, in_quat_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/pcr_res_if.sv =====
// Result channel: output pose or transformed point.
`default_nettype none

interface pcr_res_if
    import pcr_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [POS_WIDTH-1:0]  out_pos_x;
    logic signed [POS_WIDTH-1:0]  out_pos_y;
    logic signed [POS_WIDTH-1:0]  out_pos_z;
    logic signed [QUAT_WIDTH-1:0] out_quat_w;
    logic signed [QUAT_WIDTH-1:0] out_quat_x;
    logic signed [QUAT_WIDTH-1:0] out_quat_y;
    logic signed [QUAT_WIDTH-1:0] out_quat_z;

    modport source (
        output valid, out_pos_x, out_pos_y, out_pos_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z,
        input  ready
    );
    modport sink (
        input  valid, out_pos_x, out_pos_y, out_pos_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/pcr_rootdiv.sv =====
// Bit-serial square root and restoring divider, one result bit per cycle.
`default_nettype none

module pcr_rootdiv
    import pcr_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rd_cmd_t                   cmd,
    input  logic [2*QUAT_WIDTH-3:0]   rad,
    input  logic [2*QUAT_WIDTH-4:0]   num,
    input  logic [QUAT_WIDTH-2:0]     den,
    output rd_stat_t                  stat,
    output logic [QUAT_WIDTH-2:0]     result
);
    localparam int QW   = QUAT_WIDTH;
    localparam int SW   = 2 * QW - 2;
    localparam int NW   = 2 * QW - 3;
    localparam int RW   = QW - 1;
    localparam int CNTW = $clog2(QW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            div_reg;
    logic [CNTW-1:0] cnt_reg;

    logic [SW-1:0]   x_reg, r_reg, bit_reg;
    logic [SW-1:0]   trial;

    logic [RW:0]     rem_reg;
    logic [RW-1:0]   lo_reg, q_reg, den_reg;
    logic [RW:0]     shifted;
    logic            fits;

    assign trial   = r_reg + bit_reg;
    assign shifted = {rem_reg[RW-1:0], lo_reg[RW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == '0)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            div_reg <= cmd.is_div;
            cnt_reg <= CNTW'(QW - 2);
            x_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= SW'(1) << (SW - 2);
            rem_reg <= (RW + 1)'(num[NW-1:QW-1]);
            lo_reg  <= num[RW-1:0];
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (div_reg)
            begin
                rem_reg <= fits ? shifted - {1'b0, den_reg} : shifted;
                lo_reg  <= lo_reg << 1;
                q_reg   <= {q_reg[RW-2:0], fits};
            end
            else
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = div_reg ? q_reg : r_reg[RW-1:0];

endmodule

`default_nettype wire

// ===== design/pose_compose_relative_unit.sv =====
// Fixed-point rigid pose unit: load, compose, relative and point transform.
//
//   channel  dir  payload                                   handshake
//   req      in   func, in_pos_x/y/z, in_quat_w/x/y/z       valid/ready
//   res      out  out_pos_x/y/z, out_quat_w/x/y/z           valid/ready
//
// Transform runs 9 pair products and 9 matrix-vector products through the
// one shared multiplier. Compose and relative add 16 Hamilton terms, a
// normalizing shift, 4 squares, a QUAT_WIDTH-1 step root and four
// QUAT_WIDTH-1 step divides on the serial root/divider. Reset loads the
// identity reference pose. The unit takes one request at a time; a
// finished result waits in the output register while the next request
// is accepted.
`default_nettype none

module pose_compose_relative_unit
    import pcr_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pcr_req_if.sink   req,
    pcr_res_if.source res
);
    localparam int PW   = POS_WIDTH;
    localparam int QW   = QUAT_WIDTH;
    localparam int XW   = (PW > QW) ? PW : QW;
    localparam int UW   = QW + 1;
    localparam int VW   = PW + 1;
    localparam int PAW  = QW + 2;
    localparam int MW   = QW + 5;
    localparam int AW   = QW + 2;
    localparam int BW   = XW + 2;
    localparam int PRW  = AW + BW;
    localparam int ACCW = XW + 6;
    localparam int CW   = QW + 5;
    localparam int SW   = 2 * QW - 2;
    localparam int NW   = 2 * QW - 3;
    localparam int RW   = QW - 1;
    localparam int ML   = QW - 2;

    localparam logic [PRW-1:0] RND_HALF = PRW'(1) << (QW - 3);
    localparam logic signed [MW-1:0] ONE_M = MW'(1) << (QW - 2);
    localparam logic signed [MW-1:0] QM_HI = MW'((MW'(1) << (QW - 1)) - MW'(1));
    localparam logic signed [MW-1:0] QM_LO = -QM_HI - MW'(1);
    localparam logic signed [ACCW-1:0] PM_HI =
        ACCW'((ACCW'(1) << (PW - 1)) - ACCW'(1));
    localparam logic signed [ACCW-1:0] PM_LO = -PM_HI - ACCW'(1);
    localparam logic [CW-1:0] ONE_C  = CW'(1) << (QW - 2);
    localparam logic [CW-1:0] HALF_C = CW'(1) << (QW - 3);
    localparam logic [RW-1:0] ONE_R  = RW'(1) << (QW - 2);
    localparam logic signed [QW-1:0] ONE_Q = QW'(1) << (QW - 2);

    function automatic logic signed [QW-1:0] sat_q(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] r;
        r = (v > QM_HI) ? QM_HI : ((v < QM_LO) ? QM_LO : v);
        return r[QW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] sat_p(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] r;
        r = (v > PM_HI) ? PM_HI : ((v < PM_LO) ? PM_LO : v);
        return r[PW-1:0];
    endfunction

    // reference pose
    logic signed [PW-1:0]   refpos_reg [3];
    logic signed [QW-1:0]   refq_reg   [4];

    state_t                 state_reg, state_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [1:0]             row_reg, row_next;
    logic [1:0]             col_reg, col_next;
    func_t                  func_reg;

    logic signed [UW-1:0]   quse_reg [4];
    logic signed [QW-1:0]   inq_reg  [4];
    logic signed [VW-1:0]   v_reg    [3];
    logic signed [PAW-1:0]  pair_reg [9];
    logic signed [QW-1:0]   m_reg    [9];
    logic signed [MW-1:0]   mw       [9];
    logic signed [PRW-1:0]  prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [PW-1:0]   pos_res_reg [3];
    logic signed [CW-1:0]   c_reg    [4];
    logic [CW-1:0]          mag_reg  [4];
    logic [CW-1:0]          mag_c    [4];
    logic                   neg_reg  [4];
    logic [CW-1:0]          top_reg, top_c;
    logic [SW-1:0]          sum_reg;
    logic [RW-1:0]          n_reg;
    logic signed [QW-1:0]   nq_reg   [4];

    logic                   ovalid_reg;
    logic signed [PW-1:0]   opos_reg [3];
    logic signed [QW-1:0]   oquat_reg [4];

    op_pair_t               pop;
    ham_term_t              hop;
    logic [3:0]             m_idx;
    logic [ML-1:0]          mag_lo;
    logic signed [AW-1:0]   a_op;
    logic signed [BW-1:0]   b_op;
    logic [PRW-1:0]         rnd_sum;
    logic signed [ACCW-1:0] rnd_val, acc_base, acc_sum, pos_full;
    logic                   out_load;

    rd_cmd_t                rd_cmd;
    rd_stat_t               rd_stat;
    logic [NW-1:0]          rd_num;
    logic [RW-1:0]          rd_res;

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_OUT) && (!ovalid_reg || res.ready);

    // ---------------- operand select and shared multiplier ----------------
    assign pop    = pair_ops(cnt_reg);
    assign hop    = ham_ops(cnt_reg);
    assign m_idx  = 4'(row_reg) * 4'd3 + 4'(col_reg);
    assign mag_lo = mag_reg[cnt_reg[1:0]][ML-1:0];

    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (state_reg)
            S_PAIR_MUL:
            begin
                a_op = AW'(quse_reg[pop.a]);
                b_op = BW'(quse_reg[pop.b]);
            end
            S_ROT_MUL:
            begin
                a_op = AW'(m_reg[m_idx]);
                b_op = BW'(v_reg[col_reg]);
            end
            S_HAM_MUL:
            begin
                a_op = AW'(quse_reg[hop.a]);
                b_op = BW'(inq_reg[hop.b]);
            end
            S_SQ_MUL:
            begin
                a_op = signed'({{(AW - ML){1'b0}}, mag_lo});
                b_op = signed'({{(BW - ML){1'b0}}, mag_lo});
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // round half up, then floor shift by the quaternion fraction bits
    assign rnd_sum = prod_reg + RND_HALF;
    assign rnd_val = signed'(rnd_sum[QW-2 +: ACCW]);

    always_comb
    begin
        acc_base = acc_reg;
        if ((state_reg == S_ROT_ACC && col_reg == 2'd0) ||
            (state_reg == S_HAM_ACC && cnt_reg[1:0] == 2'd0))
        begin
            acc_base = '0;
        end
        if (state_reg == S_HAM_ACC && hop.neg)
        begin
            acc_sum = acc_base - rnd_val;
        end
        else
        begin
            acc_sum = acc_base + rnd_val;
        end
        pos_full = acc_sum;
        if (func_reg != FN_RELATIVE)
        begin
            pos_full = acc_sum + ACCW'(refpos_reg[row_reg]);
        end
    end

    // rotation matrix from the stored pair products
    always_comb
    begin
        mw[0] = ONE_M - ((MW'(pair_reg[PR_YY]) + MW'(pair_reg[PR_ZZ])) <<< 1);
        mw[1] = (MW'(pair_reg[PR_XY]) - MW'(pair_reg[PR_WZ])) <<< 1;
        mw[2] = (MW'(pair_reg[PR_XZ]) + MW'(pair_reg[PR_WY])) <<< 1;
        mw[3] = (MW'(pair_reg[PR_XY]) + MW'(pair_reg[PR_WZ])) <<< 1;
        mw[4] = ONE_M - ((MW'(pair_reg[PR_XX]) + MW'(pair_reg[PR_ZZ])) <<< 1);
        mw[5] = (MW'(pair_reg[PR_YZ]) - MW'(pair_reg[PR_WX])) <<< 1;
        mw[6] = (MW'(pair_reg[PR_XZ]) - MW'(pair_reg[PR_WY])) <<< 1;
        mw[7] = (MW'(pair_reg[PR_YZ]) + MW'(pair_reg[PR_WX])) <<< 1;
        mw[8] = ONE_M - ((MW'(pair_reg[PR_XX]) + MW'(pair_reg[PR_YY])) <<< 1);
    end

    // magnitudes and the largest one of the raw product
    always_comb
    begin
        top_c = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag_c[i] = c_reg[i][CW-1] ? CW'(-c_reg[i]) : CW'(c_reg[i]);
            if (mag_c[i] > top_c)
            begin
                top_c = mag_c[i];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        rd_cmd     = '{start: 1'b0, is_div: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && func_t'(req.func) != FN_LOAD)
                begin
                    state_next = S_PAIR_MUL;
                    cnt_next   = '0;
                end
            end
            S_PAIR_MUL: state_next = S_PAIR_ACC;
            S_PAIR_ACC:
            begin
                if (cnt_reg == PR_WZ)
                begin
                    cnt_next   = '0;
                    state_next = S_MAT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_PAIR_MUL;
                end
            end
            S_MAT:
            begin
                row_next   = '0;
                col_next   = '0;
                state_next = S_ROT_MUL;
            end
            S_ROT_MUL: state_next = S_ROT_ACC;
            S_ROT_ACC:
            begin
                state_next = S_ROT_MUL;
                if (col_reg == 2'd2)
                begin
                    col_next = '0;
                    if (row_reg == 2'd2)
                    begin
                        row_next   = '0;
                        cnt_next   = '0;
                        state_next = (func_reg == FN_TRANSFORM) ? S_OUT : S_HAM_MUL;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_HAM_MUL: state_next = S_HAM_ACC;
            S_HAM_ACC:
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg == 4'd15) ? S_TOP : S_HAM_MUL;
            end
            S_TOP: state_next = (top_c == '0) ? S_OUT : S_SHIFT;
            S_SHIFT:
            begin
                if (top_reg < ONE_C && top_reg >= HALF_C)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL: state_next = S_SQ_ACC;
            S_SQ_ACC:
            begin
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT_GO;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT_GO:
            begin
                rd_cmd     = '{start: 1'b1, is_div: 1'b0};
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (rd_stat.done)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                rd_cmd     = '{start: 1'b1, is_div: 1'b1};
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (rd_stat.done)
                begin
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // reference pose, replaced by a load request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refpos_reg[0] <= '0;
            refpos_reg[1] <= '0;
            refpos_reg[2] <= '0;
            refq_reg[0]   <= ONE_Q;
            refq_reg[1]   <= '0;
            refq_reg[2]   <= '0;
            refq_reg[3]   <= '0;
        end
        else if (req.valid && req.ready && func_t'(req.func) == FN_LOAD)
        begin
            refpos_reg[0] <= req.in_pos_x;
            refpos_reg[1] <= req.in_pos_y;
            refpos_reg[2] <= req.in_pos_z;
            refq_reg[0]   <= req.in_quat_w;
            refq_reg[1]   <= req.in_quat_x;
            refq_reg[2]   <= req.in_quat_y;
            refq_reg[3]   <= req.in_quat_z;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_reg   <= func_t'(req.func);
                    inq_reg[0] <= req.in_quat_w;
                    inq_reg[1] <= req.in_quat_x;
                    inq_reg[2] <= req.in_quat_y;
                    inq_reg[3] <= req.in_quat_z;
                    quse_reg[0] <= UW'(refq_reg[0]);
                    // relative uses the conjugate and the offset from the reference
                    if (func_t'(req.func) == FN_RELATIVE)
                    begin
                        quse_reg[1] <= -UW'(refq_reg[1]);
                        quse_reg[2] <= -UW'(refq_reg[2]);
                        quse_reg[3] <= -UW'(refq_reg[3]);
                        v_reg[0] <= VW'(req.in_pos_x) - VW'(refpos_reg[0]);
                        v_reg[1] <= VW'(req.in_pos_y) - VW'(refpos_reg[1]);
                        v_reg[2] <= VW'(req.in_pos_z) - VW'(refpos_reg[2]);
                    end
                    else
                    begin
                        quse_reg[1] <= UW'(refq_reg[1]);
                        quse_reg[2] <= UW'(refq_reg[2]);
                        quse_reg[3] <= UW'(refq_reg[3]);
                        v_reg[0] <= VW'(req.in_pos_x);
                        v_reg[1] <= VW'(req.in_pos_y);
                        v_reg[2] <= VW'(req.in_pos_z);
                    end
                end
            end
            S_PAIR_MUL, S_ROT_MUL, S_HAM_MUL, S_SQ_MUL:
            begin
                prod_reg <= a_op * b_op;
            end
            S_PAIR_ACC:
            begin
                pair_reg[cnt_reg] <= PAW'(rnd_val);
            end
            S_MAT:
            begin
                for (int k = 0; k < 9; k++)
                begin
                    m_reg[k] <= sat_q(mw[k]);
                end
            end
            S_ROT_ACC:
            begin
                acc_reg <= acc_sum;
                if (col_reg == 2'd2)
                begin
                    pos_res_reg[row_reg] <= sat_p(pos_full);
                end
            end
            S_HAM_ACC:
            begin
                acc_reg <= acc_sum;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    c_reg[cnt_reg[3:2]] <= CW'(acc_sum);
                end
            end
            S_TOP:
            begin
                top_reg <= top_c;
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i] <= mag_c[i];
                    neg_reg[i] <= c_reg[i][CW-1];
                end
                // zero norm maps to the identity
                nq_reg[0] <= ONE_Q;
                nq_reg[1] <= '0;
                nq_reg[2] <= '0;
                nq_reg[3] <= '0;
            end
            S_SHIFT:
            begin
                if (top_reg >= ONE_C)
                begin
                    top_reg <= top_reg >> 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (top_reg < HALF_C)
                begin
                    top_reg <= top_reg << 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_SQ_ACC:
            begin
                sum_reg <= ((cnt_reg == '0) ? '0 : sum_reg) + prod_reg[SW-1:0];
            end
            S_SQRT_WAIT:
            begin
                if (rd_stat.done)
                begin
                    n_reg <= rd_res;
                end
            end
            S_DIV_WAIT:
            begin
                if (rd_stat.done)
                begin
                    nq_reg[cnt_reg[1:0]] <= neg_reg[cnt_reg[1:0]] ? -QW'(rd_res)
                                                                  : QW'(rd_res);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rd_num = (NW'(mag_lo) << (QW - 2)) + NW'(n_reg >> 1);

    pcr_rootdiv #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_rootdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (rd_cmd),
        .rad    (sum_reg),
        .num    (rd_num),
        .den    (n_reg),
        .stat   (rd_stat),
        .result (rd_res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                opos_reg[i] <= pos_res_reg[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                oquat_reg[i] <= (func_reg == FN_TRANSFORM) ? '0 : nq_reg[i];
            end
        end
    end

    assign res.valid      = ovalid_reg;
    assign res.out_pos_x  = opos_reg[0];
    assign res.out_pos_y  = opos_reg[1];
    assign res.out_pos_z  = opos_reg[2];
    assign res.out_quat_w = oquat_reg[0];
    assign res.out_quat_x = oquat_reg[1];
    assign res.out_quat_y = oquat_reg[2];
    assign res.out_quat_z = oquat_reg[3];

    // ---------------- assertions ----------------
    a_rd_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cmd.start |-> !rd_stat.busy)
        else $error("root/divide unit started while busy");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ_MUL && cnt_reg == '0) |-> (top_reg >= HALF_C && top_reg < ONE_C))
        else $error("normalizing shift left magnitude out of range");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && rd_stat.done) |-> rd_res <= ONE_R)
        else $error("normalized component exceeds one");

endmodule

`default_nettype wire
